/* rtl/csfw_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csfw_pkg
// Shared types and constants for the counting semaphore with FIFO wait queue.
// ----------------------------------------------------------------------------
package csfw_pkg;

    // default sizes used by the top level
    localparam int WAIT_DEPTH_DEF   = 64;
    localparam int TASK_ID_BITS_DEF = 8;

    // fixed field widths
    localparam int LIMIT_W  = 16;
    localparam int STATUS_W = 3;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1);

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED  = 3'd0,
        ST_BLOCKED  = 3'd1,
        ST_RELEASED = 3'd2,
        ST_WOKEN    = 3'd3,
        ST_ERROR    = 3'd4
    } t_status;

    // request type codes
    localparam logic REQ_ACQUIRE = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;   // latch the accepted request
        logic eval;      // decide, update count and ring
        logic load_out;  // move the result into the output register
    } t_cmd;

endpackage
`default_nettype wire

/* rtl/csfw_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csfw_ctrl
// Request sequencer: accept, evaluate, then load the result register.
// ----------------------------------------------------------------------------
module csfw_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output csfw_pkg::t_cmd     o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_LOAD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   capture;
    logic   load_out;

    // command decode
    assign capture  = i_in_valid && r_in_ready;
    assign load_out = (r_state == S_LOAD) && (!r_out_valid || i_out_ready);

    assign o_cmd.capture  = capture;
    assign o_cmd.eval     = (r_state == S_EVAL);
    assign o_cmd.load_out = load_out;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (capture) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output valid: set on load, cleared when the transaction completes
    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_ready  <= (n_state == S_IDLE);
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

/* rtl/csfw_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csfw_datapath
// Holder count, limit register, wait ring memory and result registers.
// ----------------------------------------------------------------------------
module csfw_datapath #(
    parameter int WAIT_DEPTH   = csfw_pkg::WAIT_DEPTH_DEF,
    parameter int TASK_ID_BITS = csfw_pkg::TASK_ID_BITS_DEF,
    localparam int IDX_W  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1,
    localparam int FILL_W = $clog2(WAIT_DEPTH + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire csfw_pkg::t_cmd                i_cmd,
    input  wire logic                          i_cfg_we,
    input  wire logic [csfw_pkg::LIMIT_W-1:0]  i_cfg_limit,
    input  wire logic                          i_req_type,
    input  wire logic [TASK_ID_BITS-1:0]       i_task_id,
    output logic [csfw_pkg::STATUS_W-1:0]      o_status,
    output logic [TASK_ID_BITS-1:0]            o_woken_task,
    output logic [csfw_pkg::LIMIT_W-1:0]       o_holders,
    output logic [FILL_W-1:0]                  o_waiting
);

    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(WAIT_DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL     = FILL_W'(WAIT_DEPTH);

    // wait ring storage
    logic [TASK_ID_BITS-1:0] r_ring [WAIT_DEPTH];
    logic [TASK_ID_BITS-1:0] r_rd_data;

    // control state
    logic [csfw_pkg::LIMIT_W-1:0] r_limit;
    logic [csfw_pkg::LIMIT_W-1:0] r_count;
    logic [csfw_pkg::LIMIT_W-1:0] n_count;
    logic [IDX_W-1:0]             r_head;
    logic [IDX_W-1:0]             n_head;
    logic [IDX_W-1:0]             r_tail;
    logic [IDX_W-1:0]             n_tail;
    logic [FILL_W-1:0]            r_fill;
    logic [FILL_W-1:0]            n_fill;

    // request and result payload
    logic                         r_req_type;
    logic [TASK_ID_BITS-1:0]      r_task_id;
    csfw_pkg::t_status            r_res_status;
    csfw_pkg::t_status            n_status;
    logic                         push;
    logic                         pop;
    csfw_pkg::t_status            r_o_status;
    logic [TASK_ID_BITS-1:0]      r_o_woken;
    logic [csfw_pkg::LIMIT_W-1:0] r_o_holders;
    logic [FILL_W-1:0]            r_o_waiting;

    // request decision
    always_comb begin
        n_status = csfw_pkg::ST_ERROR;
        n_count  = r_count;
        n_head   = r_head;
        n_tail   = r_tail;
        n_fill   = r_fill;
        push     = 1'b0;
        pop      = 1'b0;
        if (r_req_type == csfw_pkg::REQ_ACQUIRE) begin
            if (r_count < r_limit) begin
                n_count  = r_count + 1'b1;
                n_status = csfw_pkg::ST_GRANTED;
            end else if (r_fill != FULL) begin
                push     = 1'b1;
                n_tail   = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;
                n_fill   = r_fill + 1'b1;
                n_status = csfw_pkg::ST_BLOCKED;
            end
        end else begin
            if (r_fill != '0) begin
                pop      = 1'b1;
                n_head   = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
                n_fill   = r_fill - 1'b1;
                n_status = csfw_pkg::ST_WOKEN;
            end else if (r_count != '0) begin
                n_count  = r_count - 1'b1;
                n_status = csfw_pkg::ST_RELEASED;
            end
        end
    end

    // limit, count and ring pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= csfw_pkg::LIMIT_RESET;
            r_count <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_fill  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_limit;
            end
            if (i_cmd.eval) begin
                r_count <= n_count;
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_fill  <= n_fill;
            end
        end
    end

    // ring memory: one write or one registered read per evaluation
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval && push) begin
            r_ring[r_tail] <= r_task_id;
        end
        if (i_cmd.eval && pop) begin
            r_rd_data <= r_ring[r_head];
        end
    end

    // request capture, pending status and output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req_type <= i_req_type;
            r_task_id  <= i_task_id;
        end
        if (i_cmd.eval) begin
            r_res_status <= n_status;
        end
        if (i_cmd.load_out) begin
            r_o_status  <= r_res_status;
            r_o_woken   <= (r_res_status == csfw_pkg::ST_WOKEN) ? r_rd_data : '0;
            r_o_holders <= r_count;
            r_o_waiting <= r_fill;
        end
    end

    assign o_status     = r_o_status;
    assign o_woken_task = r_o_woken;
    assign o_holders    = r_o_holders;
    assign o_waiting    = r_o_waiting;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL)
        else $error("wait ring fill exceeds depth");

    a_block_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.eval && (n_status == csfw_pkg::ST_BLOCKED)
        |=> r_fill == $past(r_fill) + 1'b1)
        else $error("blocked request did not enqueue");

    a_error_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.eval && (n_status == csfw_pkg::ST_ERROR)
        |=> $stable(r_count) && $stable(r_fill) && $stable(r_head) && $stable(r_tail))
        else $error("error request changed state");

    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && !i_cmd.eval |=> $stable(r_count) && $stable(r_fill))
        else $error("count or fill changed outside evaluation");

    a_woken_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.eval && (n_status == csfw_pkg::ST_WOKEN) |=> $stable(r_count))
        else $error("waiter handoff changed holder count");
`endif

endmodule
`default_nettype wire

/* rtl/counting_semaphore_fifo_wait_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// counting_semaphore_fifo_wait_top
// Counting semaphore with a FIFO queue of waiting task IDs.
// ----------------------------------------------------------------------------
// Each input transaction is an acquire or a release and yields exactly one
// result transaction. A request is captured at its accepting edge, evaluated at
// the next edge in S_EVAL and then loaded into the output register in S_LOAD,
// which waits while an unread result still holds that register. The wait ring
// memory has a single port whose read data is registered. The next request is
// accepted in the cycle after the result is loaded, so no new request is taken
// while the last one is still in evaluation or waiting to load. A result
// waiting in the output register does not stop the next request from being
// accepted and evaluated. The limit register resets to 1 and is written through
// the configuration channel, which is always ready; write it only while idle.
// The wait ring needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module counting_semaphore_fifo_wait_top #(
    parameter int WAIT_DEPTH   = csfw_pkg::WAIT_DEPTH_DEF,
    parameter int TASK_ID_BITS = csfw_pkg::TASK_ID_BITS_DEF,
    localparam int FILL_W = $clog2(WAIT_DEPTH + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // request channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_req_type,
    input  wire logic [TASK_ID_BITS-1:0]       i_task_id,
    // result channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [csfw_pkg::STATUS_W-1:0]      o_status,
    output logic [TASK_ID_BITS-1:0]            o_woken_task,
    output logic [csfw_pkg::LIMIT_W-1:0]       o_holders,
    output logic [FILL_W-1:0]                  o_waiting,
    // configuration channel
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [csfw_pkg::LIMIT_W-1:0]  i_cfg_limit
);

    csfw_pkg::t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    // sequencer
    csfw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // count, ring and result registers
    csfw_datapath #(
        .WAIT_DEPTH   (WAIT_DEPTH),
        .TASK_ID_BITS (TASK_ID_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_limit  (i_cfg_limit),
        .i_req_type   (i_req_type),
        .i_task_id    (i_task_id),
        .o_status     (o_status),
        .o_woken_task (o_woken_task),
        .o_holders    (o_holders),
        .o_waiting    (o_waiting)
    );

endmodule
`default_nettype wire

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb: counting semaphore with FIFO wait queue
// This bench sends acquire and release requests through the request channel
// and runs its own model of the holder count and the ring of waiting task IDs.
// Each returned result is compared, field by field, with the oldest predicted
// one. A short directed list comes first. It is followed by runs of acquires
// and releases under several limit settings, including zero and full scale.
// Both sides of the handshake stall at random.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WAIT_DEPTH = csfw_pkg::WAIT_DEPTH_DEF;
    localparam int ID_W       = csfw_pkg::TASK_ID_BITS_DEF;
    localparam int FILL_W     = $clog2(WAIT_DEPTH + 1);
    localparam int LIM_W      = csfw_pkg::LIMIT_W;

    typedef struct {
        logic            req;
        logic [ID_W-1:0] id;
    } t_request;

    typedef struct {
        csfw_pkg::t_status  status;
        logic [ID_W-1:0]    woken;
        logic [LIM_W-1:0]   holders;
        logic [FILL_W-1:0]  waiting;
    } t_outcome;

    // DUT signals
    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_in_valid  = 1'b0;
    logic                           o_in_ready;
    logic                           i_req_type  = csfw_pkg::REQ_ACQUIRE;
    logic [ID_W-1:0]                i_task_id   = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    logic [csfw_pkg::STATUS_W-1:0]  o_status;
    logic [ID_W-1:0]                o_woken_task;
    logic [LIM_W-1:0]               o_holders;
    logic [FILL_W-1:0]              o_waiting;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [LIM_W-1:0]               i_cfg_limit = '0;

    // semaphore model state
    logic [LIM_W-1:0]     sem_limit = csfw_pkg::LIMIT_RESET;
    logic [LIM_W-1:0]     sem_holders = '0;
    logic [ID_W-1:0]      wait_ring [WAIT_DEPTH];
    int                   ring_head = 0;
    int                   ring_tail = 0;
    int                   ring_fill = 0;

    // bench bookkeeping
    t_request             pending_q [$];
    t_outcome             outcome_q [$];
    int                   send_idle_pct  = 0;
    int                   recv_stall_pct = 0;
    int                   n_errors       = 0;
    int                   n_results      = 0;
    int                   n_limits       = 0;
    int                   deepest_queue  = 0;
    int                   status_seen [5] = '{default: 0};

    counting_semaphore_fifo_wait_top #(
        .WAIT_DEPTH   (WAIT_DEPTH),
        .TASK_ID_BITS (ID_W)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_task_id    (i_task_id),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_woken_task (o_woken_task),
        .o_holders    (o_holders),
        .o_waiting    (o_waiting),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_limit  (i_cfg_limit)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // apply one request to the semaphore model and return its outcome
    function automatic t_outcome serve_request(input logic req, input logic [ID_W-1:0] id);
        t_outcome res;
        res.woken = '0;
        if (req == csfw_pkg::REQ_ACQUIRE) begin
            if (sem_holders < sem_limit) begin
                sem_holders = sem_holders + 1'b1;
                res.status  = csfw_pkg::ST_GRANTED;
            end else if (ring_fill >= WAIT_DEPTH) begin
                res.status = csfw_pkg::ST_ERROR;
            end else begin
                wait_ring[ring_tail] = id;
                ring_tail  = (ring_tail + 1) % WAIT_DEPTH;
                ring_fill++;
                res.status = csfw_pkg::ST_BLOCKED;
            end
        end else begin
            if (ring_fill > 0) begin
                // grant passes straight to the oldest waiter, count unchanged
                res.woken  = wait_ring[ring_head];
                ring_head  = (ring_head + 1) % WAIT_DEPTH;
                ring_fill--;
                res.status = csfw_pkg::ST_WOKEN;
            end else if (sem_holders == '0) begin
                res.status = csfw_pkg::ST_ERROR;
            end else begin
                sem_holders = sem_holders - 1'b1;
                res.status  = csfw_pkg::ST_RELEASED;
            end
        end
        res.holders = sem_holders;
        res.waiting = FILL_W'(ring_fill);
        if (ring_fill > deepest_queue)
            deepest_queue = ring_fill;
        return res;
    endfunction

    // request driver: predicts on acceptance, then loads the next pending item
    always @(posedge i_clk) begin : request_drive
        t_request nxt;
        if (i_in_valid && o_in_ready) begin
            outcome_q.push_back(serve_request(i_req_type, i_task_id));
            status_seen[outcome_q[$].status]++;
        end
        if (!i_in_valid || o_in_ready) begin
            if (i_rst_n && pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_q.pop_front();
                i_in_valid <= 1'b1;
                i_req_type <= nxt.req;
                i_task_id  <= nxt.id;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin : result_check
        t_outcome want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (outcome_q.size() == 0) begin
                $error("result with no request outstanding: status %0d", o_status);
                n_errors++;
            end else begin
                want = outcome_q.pop_front();
                if (o_status !== want.status) begin
                    $error("status expected %0d got %0d", want.status, o_status);
                    n_errors++;
                end
                if (o_woken_task !== want.woken) begin
                    $error("woken_task expected 0x%0h got 0x%0h", want.woken, o_woken_task);
                    n_errors++;
                end
                if (o_holders !== want.holders) begin
                    $error("holders expected %0d got %0d", want.holders, o_holders);
                    n_errors++;
                end
                if (o_waiting !== want.waiting) begin
                    $error("waiting expected %0d got %0d", want.waiting, o_waiting);
                    n_errors++;
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic queue_item(input logic req, input logic [ID_W-1:0] id);
        t_request r;
        r.req = req;
        r.id  = id;
        pending_q.push_back(r);
    endtask

    // wait until every request was sent and every result came back
    task automatic drain();
        while (pending_q.size() > 0 || i_in_valid || outcome_q.size() > 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [LIM_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_limit <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sem_limit = value;
        n_limits++;
        i_cfg_valid <= 1'b0;
    endtask

    // runs of acquires or releases with random IDs, plus scattered noise
    task automatic queue_runs(input int count);
        int   sent;
        int   run_len;
        logic run_req;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 10) begin
                run_len = 1;
                run_req = 1'($urandom_range(1));
            end else begin
                run_len = $urandom_range(1, 80);
                run_req = ($urandom_range(99) < 52) ? csfw_pkg::REQ_ACQUIRE
                                                    : csfw_pkg::REQ_RELEASE;
            end
            if (run_len > count - sent)
                run_len = count - sent;
            repeat (run_len) begin
                queue_item(run_req, ID_W'($urandom_range(255)));
                sent++;
            end
        end
    endtask

    // stimulus
    initial begin : stimulus
        logic [LIM_W-1:0] limits [9];
        limits = '{16'd2, 16'hFFFF, 16'd0, 16'd7, LIM_W'($urandom),
                   16'd1, 16'd3, LIM_W'($urandom_range(4, 20)), 16'd40};

        send_idle_pct  = 21;
        recv_stall_pct = 77;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset limit of one: empty release, grant, queue, wake in order
        queue_item(csfw_pkg::REQ_RELEASE, 8'h00);
        queue_item(csfw_pkg::REQ_ACQUIRE, 8'h00);
        queue_item(csfw_pkg::REQ_ACQUIRE, 8'hFF);
        queue_item(csfw_pkg::REQ_ACQUIRE, 8'hA5);
        queue_item(csfw_pkg::REQ_ACQUIRE, 8'h5A);
        repeat (4) queue_item(csfw_pkg::REQ_RELEASE, 8'h33);
        queue_item(csfw_pkg::REQ_RELEASE, 8'hFF);
        drain();

        // zero limit: every acquire waits
        write_limit(16'd0);
        queue_item(csfw_pkg::REQ_ACQUIRE, 8'h01);
        queue_item(csfw_pkg::REQ_ACQUIRE, 8'h80);
        repeat (3) queue_item(csfw_pkg::REQ_RELEASE, 8'hFF);
        drain();

        // limit lowered below the holder count
        write_limit(16'd3);
        repeat (3) queue_item(csfw_pkg::REQ_ACQUIRE, 8'h11);
        drain();
        write_limit(16'd1);
        queue_item(csfw_pkg::REQ_ACQUIRE, 8'h7E);
        repeat (4) queue_item(csfw_pkg::REQ_RELEASE, 8'h00);
        drain();

        // random sections, idle pattern changes every third section
        for (int s = 0; s < 9; s++) begin
            if (s == 3) begin
                send_idle_pct  = 77;
                recv_stall_pct = 21;
            end else if (s == 6) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            write_limit(limits[s]);
            queue_runs(200);
            drain();
        end

        repeat (10) @(posedge i_clk);
        $display("Checked %0d results over %0d limit settings, deepest wait queue %0d",
                 n_results, n_limits, deepest_queue);
        $display("granted %0d, blocked %0d, released %0d, woken %0d, rejected %0d",
                 status_seen[csfw_pkg::ST_GRANTED], status_seen[csfw_pkg::ST_BLOCKED],
                 status_seen[csfw_pkg::ST_RELEASED], status_seen[csfw_pkg::ST_WOKEN],
                 status_seen[csfw_pkg::ST_ERROR]);
        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
rtl/csfw_pkg.sv
rtl/csfw_ctrl.sv
rtl/csfw_datapath.sv
rtl/counting_semaphore_fifo_wait_top.sv
verif/tb.sv
